// ===== design/iabl_pkg.sv =====
// ----------------------------------------------------------------------------
// Icon alpha blend package
// Word types, register indexes and fixed widths shared by the blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package iabl_pkg;

  localparam int unsigned COL_W    = 9;
  localparam int unsigned DIVN_W   = COL_W + 8;
  localparam int unsigned QUEUE_D  = 4;
  localparam int unsigned QPTR_W   = 2;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CIDX_W   = 2;
  localparam int unsigned SCALE_W  = 4;
  localparam int unsigned SIDE_W   = 7;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_BLEND = 1'b1;

  typedef enum logic [CIDX_W-1:0] {
    REG_SCALE  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        command;
    logic [11:0] texel_index;
    logic [7:0]  texel_alpha;
    logic [8:0]  scaled_col;
    logic [8:0]  scaled_row;
    logic [23:0] background_rgb;
  } in_word_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        pixel_written;
  } out_word_t;

  typedef struct packed {
    logic     is_blend;
    logic     load_ok;
    in_word_t word;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] f);
    logic [16:0] sum;
    sum = 17'(a) * (17'd256 - 17'(f)) + 17'(b) * 17'(f);
    return sum[15:8];
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== design/icon_bilinear_alpha_blend_unit.sv =====
// ----------------------------------------------------------------------------
// Icon bilinear alpha blend unit
// Upscales a stored icon alpha plane bilinearly and blends white over pixels.
//
// Input words are pushed with in_push while in_full is low. A load word writes
// one texel alpha of the icon; a blend word carries a position in the scaled
// icon and a background pixel and yields one result word. Results leave in
// order: out_word is valid while out_empty is low and is taken with out_pop.
// One word is accepted per clock while in_full is low. A blend result passes
// through the input queue and then the seven-register back-end pipeline to
// the output ports; loads enter the same path and write the texel store in
// order with the blends.
// When the receiver stalls the back end holds, the input queue absorbs up to
// four words, then in_full rises. Reset empties the queue and pipeline and
// sets scale 1 and a 64 by 64 icon; the texel store is not cleared and must
// be loaded before use. Configuration must be written through cfg_we,
// cfg_index and cfg_data only while idle; the unit does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module icon_bilinear_alpha_blend_unit #(
  parameter int unsigned MAX_ICON_SIDE = 64,
  parameter int unsigned MAX_SCALE     = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  input  iabl_pkg::in_word_t               in_word,
  output logic                             in_full,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output iabl_pkg::out_word_t              out_word,
  input  wire logic                        cfg_we,
  input  wire logic [iabl_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [iabl_pkg::CFG_W-1:0]  cfg_data
);
  import iabl_pkg::*;

  localparam int unsigned SCW = $clog2(MAX_SCALE + 1);
  localparam int unsigned SW  = $clog2(MAX_ICON_SIDE) + 1;

  logic [SCALE_W-1:0] scale_r;
  logic [SIDE_W-1:0]  width_r;
  logic [SIDE_W-1:0]  height_r;
  logic [SCW-1:0]     scale_c;
  logic [SW-1:0]      width_c;
  logic [SW-1:0]      height_c;
  queue_head_t        head;
  logic               head_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_W'(1);
      width_r  <= SIDE_W'(64);
      height_r <= SIDE_W'(64);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCALE:  scale_r  <= cfg_data[SCALE_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data[SIDE_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale_r == '0) begin
      scale_c = SCW'(1);
    end else if (32'(scale_r) > 32'(MAX_SCALE)) begin
      scale_c = SCW'(MAX_SCALE);
    end else begin
      scale_c = SCW'(scale_r);
    end
    if (width_r == '0) begin
      width_c = SW'(1);
    end else if (32'(width_r) > 32'(MAX_ICON_SIDE)) begin
      width_c = SW'(MAX_ICON_SIDE);
    end else begin
      width_c = SW'(width_r);
    end
    if (height_r == '0) begin
      height_c = SW'(1);
    end else if (32'(height_r) > 32'(MAX_ICON_SIDE)) begin
      height_c = SW'(MAX_ICON_SIDE);
    end else begin
      height_c = SW'(height_r);
    end
  end

  iabl_front #(
    .STORE_DEPTH (MAX_ICON_SIDE * MAX_ICON_SIDE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .head     (head),
    .head_pop (head_pop)
  );

  iabl_back #(
    .MAX_ICON_SIDE (MAX_ICON_SIDE),
    .MAX_SCALE     (MAX_SCALE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_pop  (head_pop),
    .scale     (scale_c),
    .icon_w    (width_c),
    .icon_h    (height_c),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== design/iabl_front.sv =====
// ----------------------------------------------------------------------------
// Icon alpha blend front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iabl_front #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  iabl_pkg::in_word_t      in_word,
  output logic                    in_full,
  output iabl_pkg::queue_head_t   head,
  input  wire logic               head_pop
);
  import iabl_pkg::*;

  queue_entry_t         slot_r [QUEUE_D];
  logic [QPTR_W-1:0]    wr_ptr_r;
  logic [QPTR_W-1:0]    rd_ptr_r;
  logic [QPTR_W:0]      count_r;
  logic                 push_ok;
  logic                 pop_ok;
  queue_entry_t         cls;

  assign in_full = (count_r == (QPTR_W+1)'(QUEUE_D));
  assign push_ok = in_push && !in_full;
  assign pop_ok  = head_pop && (count_r != '0);

  always_comb begin
    cls.word     = in_word;
    cls.is_blend = (in_word.command == CMD_BLEND);
    cls.load_ok  = (in_word.command == CMD_LOAD) &&
                   (32'(in_word.texel_index) < 32'(STORE_DEPTH));
  end

  assign head.valid = (count_r != '0);
  assign head.entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/iabl_store.sv =====
// ----------------------------------------------------------------------------
// Icon alpha blend texel store
// Two mirrored alpha planes, each read at two addresses, giving four texels.
// ----------------------------------------------------------------------------
`default_nettype none

module iabl_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] ra00,
  input  wire logic [AW-1:0] ra01,
  input  wire logic [AW-1:0] ra10,
  input  wire logic [AW-1:0] ra11,
  output logic [7:0]         rd00,
  output logic [7:0]         rd01,
  output logic [7:0]         rd10,
  output logic [7:0]         rd11
);

  logic [7:0] mem_top [DEPTH];
  logic [7:0] mem_bot [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_top[waddr] <= wdata;
        mem_bot[waddr] <= wdata;
      end
      rd00 <= mem_top[ra00];
      rd01 <= mem_top[ra01];
      rd10 <= mem_bot[ra10];
      rd11 <= mem_bot[ra11];
    end
  end

endmodule

`default_nettype wire

// ===== design/iabl_back.sv =====
// ----------------------------------------------------------------------------
// Icon alpha blend back end
// Maps pixels to the source, fetches texels, interpolates and blends white.
// ----------------------------------------------------------------------------
`default_nettype none

module iabl_back #(
  parameter int unsigned MAX_ICON_SIDE = 64,
  parameter int unsigned MAX_SCALE     = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  iabl_pkg::queue_head_t                       head,
  output logic                                        head_pop,
  input  wire logic [$clog2(MAX_SCALE+1)-1:0]         scale,
  input  wire logic [$clog2(MAX_ICON_SIDE)  :0]       icon_w,
  input  wire logic [$clog2(MAX_ICON_SIDE)  :0]       icon_h,
  output logic                                        out_empty,
  input  wire logic                                   out_pop,
  output iabl_pkg::out_word_t                         out_word
);
  import iabl_pkg::*;

  localparam int unsigned SCW   = $clog2(MAX_SCALE + 1);
  localparam int unsigned XW    = $clog2(MAX_ICON_SIDE);
  localparam int unsigned SW    = XW + 1;
  localparam int unsigned DEPTH = MAX_ICON_SIDE * MAX_ICON_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned KSH   = DIVN_W + SCW;
  localparam int unsigned PW    = DIVN_W + KSH + 1;

  logic [KSH:0] recip [MAX_SCALE+1];

  assign recip[0] = '0;
  for (genvar s = 1; s <= MAX_SCALE; s++) begin : g_recip
    localparam logic [KSH:0] RC = (KSH+1)'(((64'd1 << KSH) + s - 1) / s);
    assign recip[s] = RC;
  end

  logic en;
  logic out_v_r;

  assign en       = !out_v_r || out_pop;
  assign head_pop = en && head.valid;

  // Stage 1: source position.
  logic              s1_v_r, s1_blend_r, s1_lok_r;
  logic [AW-1:0]     s1_waddr_r;
  logic [7:0]        s1_walpha_r;
  logic [DIVN_W-1:0] s1_sx_r, s1_sy_r;
  logic [23:0]       s1_bg_r;
  logic [PW-1:0]     px, py;

  assign px = PW'({head.entry.word.scaled_col, 8'd0}) * PW'(recip[scale]);
  assign py = PW'({head.entry.word.scaled_row, 8'd0}) * PW'(recip[scale]);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_blend_r  <= head.entry.is_blend;
      s1_lok_r    <= head.entry.load_ok;
      s1_waddr_r  <= AW'(head.entry.word.texel_index);
      s1_walpha_r <= head.entry.word.texel_alpha;
      s1_sx_r     <= px[KSH +: DIVN_W];
      s1_sy_r     <= py[KSH +: DIVN_W];
      s1_bg_r     <= head.entry.word.background_rgb;
    end
  end

  // Stage 2: neighbor addresses.
  logic              s2_v_r, s2_blend_r, s2_lok_r;
  logic [AW-1:0]     s2_waddr_r;
  logic [7:0]        s2_walpha_r;
  logic [AW-1:0]     s2_ra00_r, s2_ra01_r, s2_ra10_r, s2_ra11_r;
  logic [7:0]        s2_fx_r, s2_fy_r;
  logic [23:0]       s2_bg_r;
  logic [XW-1:0]     x0, y0, x1, y1;
  logic [AW-1:0]     base0, base1;

  always_comb begin
    if (32'(s1_sx_r[DIVN_W-1:8]) >= 32'(icon_w)) begin
      x0 = XW'(icon_w - 1'b1);
    end else begin
      x0 = XW'(s1_sx_r[DIVN_W-1:8]);
    end
    if (32'(s1_sy_r[DIVN_W-1:8]) >= 32'(icon_h)) begin
      y0 = XW'(icon_h - 1'b1);
    end else begin
      y0 = XW'(s1_sy_r[DIVN_W-1:8]);
    end
    if ((SW'(x0) + 1'b1) >= icon_w) begin
      x1 = XW'(icon_w - 1'b1);
    end else begin
      x1 = x0 + 1'b1;
    end
    if ((SW'(y0) + 1'b1) >= icon_h) begin
      y1 = XW'(icon_h - 1'b1);
    end else begin
      y1 = y0 + 1'b1;
    end
    base0 = AW'(AW'(y0) * AW'(icon_w));
    base1 = AW'(AW'(y1) * AW'(icon_w));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_blend_r  <= s1_blend_r;
      s2_lok_r    <= s1_lok_r;
      s2_waddr_r  <= s1_waddr_r;
      s2_walpha_r <= s1_walpha_r;
      s2_ra00_r   <= base0 + AW'(x0);
      s2_ra01_r   <= base0 + AW'(x1);
      s2_ra10_r   <= base1 + AW'(x0);
      s2_ra11_r   <= base1 + AW'(x1);
      s2_fx_r     <= s1_sx_r[7:0];
      s2_fy_r     <= s1_sy_r[7:0];
      s2_bg_r     <= s1_bg_r;
    end
  end

  // Stage 3: texel fetch, and texel loads in program order.
  logic        s3_v_r, s3_blend_r;
  logic [7:0]  s3_fx_r, s3_fy_r;
  logic [23:0] s3_bg_r;
  logic [7:0]  a00, a01, a10, a11;

  iabl_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (en),
    .we    (s2_v_r && !s2_blend_r && s2_lok_r),
    .waddr (s2_waddr_r),
    .wdata (s2_walpha_r),
    .ra00  (s2_ra00_r),
    .ra01  (s2_ra01_r),
    .ra10  (s2_ra10_r),
    .ra11  (s2_ra11_r),
    .rd00  (a00),
    .rd01  (a01),
    .rd10  (a10),
    .rd11  (a11)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s3_blend_r <= s2_blend_r;
      s3_fx_r    <= s2_fx_r;
      s3_fy_r    <= s2_fy_r;
      s3_bg_r    <= s2_bg_r;
    end
  end

  // Stage 4: horizontal interpolation.
  logic        s4_v_r, s4_blend_r;
  logic [7:0]  s4_top_r, s4_bot_r, s4_fy_r;
  logic [23:0] s4_bg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_blend_r <= s3_blend_r;
      s4_top_r   <= lerp8(a00, a01, s3_fx_r);
      s4_bot_r   <= lerp8(a10, a11, s3_fx_r);
      s4_fy_r    <= s3_fy_r;
      s4_bg_r    <= s3_bg_r;
    end
  end

  // Stage 5: vertical interpolation.
  logic        s5_v_r, s5_blend_r;
  logic [7:0]  s5_alpha_r;
  logic [23:0] s5_bg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_blend_r <= s4_blend_r;
      s5_alpha_r <= lerp8(s4_top_r, s4_bot_r, s4_fy_r);
      s5_bg_r    <= s4_bg_r;
    end
  end

  // Stage 6: per-channel weighted sums.
  logic        s6_v_r, s6_blend_r;
  logic [7:0]  s6_alpha_r;
  logic [23:0] s6_bg_r;
  logic [15:0] s6_sum_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s6_blend_r <= s5_blend_r;
      s6_alpha_r <= s5_alpha_r;
      s6_bg_r    <= s5_bg_r;
      for (int c = 0; c < 3; c++) begin
        s6_sum_r[c] <= 16'(16'd255 * 16'(s5_alpha_r)) +
                       16'(16'(s5_bg_r[c*8 +: 8]) * (16'd255 - 16'(s5_alpha_r)));
      end
    end
  end

  // Stage 7: output register.
  out_word_t out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s6_alpha_r == 8'd0) begin
        out_r.pixel_rgb     <= s6_bg_r;
        out_r.pixel_written <= 1'b0;
      end else if (s6_alpha_r == 8'hFF) begin
        out_r.pixel_rgb     <= 24'hFFFFFF;
        out_r.pixel_written <= 1'b1;
      end else begin
        out_r.pixel_rgb     <= {div255(s6_sum_r[2]), div255(s6_sum_r[1]),
                                div255(s6_sum_r[0])};
        out_r.pixel_written <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= head.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r && s3_blend_r;
      s5_v_r  <= s4_v_r && s4_blend_r;
      s6_v_r  <= s5_v_r && s5_blend_r;
      out_v_r <= s6_v_r && s6_blend_r;
    end
  end

  assign out_empty = !out_v_r;
  assign out_word  = out_r;

endmodule

`default_nettype wire
